/* sv/fsp_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// fsp_pkg: shared types and constants of the FASTA stretch parser
// Byte classes, parse phases, register indexes and the transaction types that
// move between the front end, the parser back end and the result queue.
// ----------------------------------------------------------------------------
package fsp_pkg;

  localparam int unsigned COUNT_BITS_DEF  = 32;
  localparam int unsigned QUEUE_DEPTH_DEF = 2;

  localparam int unsigned CFG_IDX_BITS = 2;

  localparam logic [CFG_IDX_BITS-1:0] CFG_AMBIGUOUS_TO_A = 2'd0;
  localparam logic [CFG_IDX_BITS-1:0] CFG_COLOR_SPACE    = 2'd1;
  localparam logic [CFG_IDX_BITS-1:0] CFG_BISULFITE_MODE = 2'd2;
  localparam logic [CFG_IDX_BITS-1:0] CFG_EMIT_SYMBOLS   = 2'd3;

  localparam logic KIND_SYMBOL = 1'b0;
  localparam logic KIND_RECORD = 1'b1;

  typedef enum logic [1:0] {
    CAT_OTHER  = 2'd0,
    CAT_BASE   = 2'd1,
    CAT_GAP    = 2'd2,
    CAT_HEADER = 2'd3
  } cat_t;

  typedef enum logic [2:0] {
    PH_START    = 3'd0,
    PH_NAME     = 3'd1,
    PH_NEWLINES = 3'd2,
    PH_SCAN     = 3'd3,
    PH_READ     = 3'd4,
    PH_DONE     = 3'd5
  } phase_t;

  typedef struct packed {
    logic ambiguous_to_a;
    logic color_space;
    logic bisulfite_mode;
    logic emit_symbols;
  } cfg_t;

  // Classified byte handed from the front end to the parser
  typedef struct packed {
    cat_t       cat;
    logic [1:0] code;
    logic       is_ws;
    logic       is_nl;
    logic       file_start;
    logic       end_of_file;
  } item_t;

  typedef struct packed {
    logic        kind;
    logic [1:0]  symbol;
    logic [31:0] gap_count;
    logic [31:0] base_count;
    logic        first_of_sequence;
    logic [31:0] sequence_count;
    logic [31:0] unambiguous_total;
    logic [63:0] all_total;
    logic        overflow_error;
  } result_t;

  typedef struct packed {
    logic error;
    logic res_push;
  } back_stat_t;

endpackage : fsp_pkg
`default_nettype wire

/* sv/fsp_fifo.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// fsp_fifo: small synchronous queue
// Register-based first-in first-out queue; head entry is shown while not empty.
// ----------------------------------------------------------------------------
module fsp_fifo #(
  parameter type         T     = logic,
  parameter int unsigned DEPTH = fsp_pkg::QUEUE_DEPTH_DEF
) (
  input  wire  logic clk,
  input  wire  logic rst_n,
  input  wire  logic push,
  input  wire  T     wdata,
  output logic       full,
  input  wire  logic pop,
  output T           rdata,
  output logic       empty
);

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  T              mem [DEPTH];
  logic [PW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          do_push, do_pop;

  assign full    = (cnt_r == CW'(DEPTH));
  assign empty   = (cnt_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = mem[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr_r] <= wdata;
    end
  end

endmodule : fsp_fifo
`default_nettype wire

/* sv/fsp_front.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// fsp_front: byte classifier and item queue
// Classifies each accepted text byte as base, gap, header marker or other,
// applies the ambiguity and bisulfite remaps, and queues it for the parser.
// ----------------------------------------------------------------------------
module fsp_front #(
  parameter int unsigned QUEUE_DEPTH = fsp_pkg::QUEUE_DEPTH_DEF
) (
  input  wire  logic           clk,
  input  wire  logic           rst_n,
  input  wire  fsp_pkg::cfg_t  cfg,
  input  wire  logic           in_push,
  output logic                 in_full,
  input  wire  logic [7:0]     in_char_byte,
  input  wire  logic           in_file_start,
  input  wire  logic           in_end_of_file,
  output fsp_pkg::item_t       item,
  output logic                 item_valid,
  input  wire  logic           item_pop
);

  fsp_pkg::item_t item_in;
  logic           item_empty;

  always_comb begin
    logic [7:0]    u;
    fsp_pkg::cat_t cat;
    u = in_char_byte;
    if (u >= "a" && u <= "z") begin
      u = u - 8'd32;
    end
    case (u)
      "A", "C", "G", "T": cat = fsp_pkg::CAT_BASE;
      "B", "D", "H", "K", "M", "N", "R", "S", "V", "W", "Y", "-":
        cat = fsp_pkg::CAT_GAP;
      ">":     cat = fsp_pkg::CAT_HEADER;
      default: cat = fsp_pkg::CAT_OTHER;
    endcase
    if (cat == fsp_pkg::CAT_GAP && cfg.ambiguous_to_a) begin
      cat = fsp_pkg::CAT_BASE;
      u   = "A";
    end
    if (cat == fsp_pkg::CAT_BASE && cfg.bisulfite_mode && u == "C") begin
      u = "T";
    end
    item_in.cat = cat;
    case (u)
      "A":     item_in.code = 2'd0;
      "C":     item_in.code = 2'd1;
      "G":     item_in.code = 2'd2;
      default: item_in.code = 2'd3;
    endcase
    item_in.is_ws = (in_char_byte == " ") ||
                    (in_char_byte >= 8'd9 && in_char_byte <= 8'd13);
    item_in.is_nl       = (in_char_byte == 8'd10) || (in_char_byte == 8'd13);
    item_in.file_start  = in_file_start;
    item_in.end_of_file = in_end_of_file;
  end

  fsp_fifo #(
    .T     (fsp_pkg::item_t),
    .DEPTH (QUEUE_DEPTH)
  ) u_item_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (in_push),
    .wdata (item_in),
    .full  (in_full),
    .pop   (item_pop),
    .rdata (item),
    .empty (item_empty)
  );

  assign item_valid = !item_empty;

endmodule : fsp_front
`default_nettype wire

/* sv/fsp_back.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// fsp_back: FASTA parse machine and stretch counters
// Runs the header/sequence phase machine one classified byte per cycle while
// res_full is low, keeps stretch counts and totals, builds symbols and records.
// ----------------------------------------------------------------------------
module fsp_back #(
  parameter int unsigned COUNT_BITS = fsp_pkg::COUNT_BITS_DEF
) (
  input  wire  logic             clk,
  input  wire  logic             rst_n,
  input  wire  fsp_pkg::cfg_t    cfg,
  input  wire  fsp_pkg::item_t   item,
  input  wire  logic             item_valid,
  output logic                   item_pop,
  input  wire  logic             res_full,
  output logic                   res_push,
  output fsp_pkg::result_t       res,
  output fsp_pkg::back_stat_t    stat
);

  localparam int unsigned CB = COUNT_BITS;

  fsp_pkg::phase_t phase_r, phase_nxt;
  logic [CB-1:0]   gap_r, gap_nxt;
  logic [CB-1:0]   base_r, base_nxt;
  logic            first_r, first_nxt;
  logic [1:0]      pb_r, pb_nxt;
  logic            pbv_r, pbv_nxt;
  logic [CB-1:0]   seq_r, seq_nxt;
  logic [CB-1:0]   una_r, una_nxt;
  logic [63:0]     all_r, all_nxt;
  logic            err_r, err_nxt;

  function automatic logic [CB:0] inc_sat(input logic [CB-1:0] v);
    if (&v) begin
      return {1'b1, v};
    end
    return {1'b0, v + 1'b1};
  endfunction

  assign item_pop = item_valid && !res_full;

  always_comb begin
    logic          fin;
    logic          fin_restart;
    logic [CB-1:0] fin_g, fin_b;
    logic          fin_f;
    logic          sym_emit;
    logic [1:0]    sym;
    logic [CB:0]   inc;
    logic [CB:0]   una_sum;
    logic [65:0]   all_sum;
    logic [63:0]   g64, b64, seq64, una64;

    phase_nxt   = phase_r;
    gap_nxt     = gap_r;
    base_nxt    = base_r;
    first_nxt   = first_r;
    pb_nxt      = pb_r;
    pbv_nxt     = pbv_r;
    seq_nxt     = seq_r;
    una_nxt     = una_r;
    all_nxt     = all_r;
    err_nxt     = err_r;
    fin         = 1'b0;
    fin_restart = 1'b0;
    fin_g       = '0;
    fin_b       = '0;
    fin_f       = 1'b0;
    sym_emit    = 1'b0;
    sym         = '0;
    inc         = '0;
    res_push    = 1'b0;

    if (item_pop) begin
      if (item.file_start) begin
        phase_nxt = fsp_pkg::PH_START;
        gap_nxt   = '0;
        base_nxt  = '0;
        first_nxt = 1'b1;
        pb_nxt    = '0;
        pbv_nxt   = 1'b0;
      end

      if (item.end_of_file) begin
        case (phase_nxt)
          fsp_pkg::PH_START, fsp_pkg::PH_NAME, fsp_pkg::PH_NEWLINES: begin
            gap_nxt   = '0;
            base_nxt  = '0;
            first_nxt = 1'b1;
            phase_nxt = fsp_pkg::PH_DONE;
            fin       = 1'b1;
          end
          fsp_pkg::PH_SCAN, fsp_pkg::PH_READ: begin
            phase_nxt = fsp_pkg::PH_DONE;
            fin       = 1'b1;
          end
          default: ;
        endcase
      end else begin
        case (phase_nxt)
          fsp_pkg::PH_START: begin
            if (!item.is_ws) begin
              phase_nxt = fsp_pkg::PH_NAME;
            end
          end
          fsp_pkg::PH_NAME: begin
            if (item.is_nl) begin
              phase_nxt = fsp_pkg::PH_NEWLINES;
            end
          end
          fsp_pkg::PH_NEWLINES: begin
            if (item.cat == fsp_pkg::CAT_HEADER) begin
              phase_nxt = fsp_pkg::PH_NAME;
            end else if (!item.is_nl) begin
              // open the sequence and treat the byte as scan input
              phase_nxt = fsp_pkg::PH_SCAN;
              gap_nxt   = '0;
              base_nxt  = '0;
              first_nxt = 1'b1;
              pbv_nxt   = 1'b0;
            end
          end
          default: ;
        endcase

        if (phase_nxt == fsp_pkg::PH_SCAN && phase_r != fsp_pkg::PH_START &&
            !(phase_r == fsp_pkg::PH_NAME && !item.file_start) &&
            (phase_r != fsp_pkg::PH_NEWLINES || item.file_start ||
             !item.is_nl)) begin
          case (item.cat)
            fsp_pkg::CAT_BASE: begin
              if (cfg.color_space && !pbv_nxt) begin
                pb_nxt  = item.code;
                pbv_nxt = 1'b1;
                if (gap_nxt != '0) begin
                  inc     = inc_sat(gap_nxt);
                  gap_nxt = inc[CB-1:0];
                  err_nxt = err_nxt | inc[CB];
                end
              end else begin
                if (cfg.color_space && gap_nxt != '0 && first_nxt) begin
                  gap_nxt = gap_nxt - 1'b1;
                end
                phase_nxt = fsp_pkg::PH_READ;
                sym_emit  = 1'b1;
              end
            end
            fsp_pkg::CAT_GAP: begin
              if (pbv_nxt && gap_nxt == '0) begin
                gap_nxt = CB'(1);
              end
              pbv_nxt = 1'b0;
              inc     = inc_sat(gap_nxt);
              gap_nxt = inc[CB-1:0];
              err_nxt = err_nxt | inc[CB];
            end
            fsp_pkg::CAT_HEADER: begin
              phase_nxt = fsp_pkg::PH_NAME;
              fin       = 1'b1;
            end
            default: ;
          endcase
        end else if (phase_nxt == fsp_pkg::PH_READ) begin
          case (item.cat)
            fsp_pkg::CAT_BASE: sym_emit = 1'b1;
            fsp_pkg::CAT_GAP: begin
              phase_nxt   = fsp_pkg::PH_SCAN;
              fin         = 1'b1;
              fin_restart = 1'b1;
            end
            fsp_pkg::CAT_HEADER: begin
              phase_nxt = fsp_pkg::PH_NAME;
              fin       = 1'b1;
            end
            default: ;
          endcase
        end
      end

      if (sym_emit) begin
        sym      = cfg.color_space ? (item.code ^ pb_nxt) : item.code;
        inc      = inc_sat(base_nxt);
        base_nxt = inc[CB-1:0];
        err_nxt  = err_nxt | inc[CB];
        pb_nxt   = item.code;
        pbv_nxt  = 1'b1;
        res_push = cfg.emit_symbols;
      end
    end

    // close the stretch: update totals and clear the stretch counters
    fin_g   = gap_nxt;
    fin_b   = base_nxt;
    fin_f   = first_nxt;
    una_sum = {1'b0, una_r} + {1'b0, fin_b};
    all_sum = 66'(all_r) + 66'(fin_b) + 66'(fin_g);
    if (fin) begin
      if (fin_f) begin
        inc     = inc_sat(seq_r);
        seq_nxt = inc[CB-1:0];
        err_nxt = err_nxt | inc[CB];
      end
      una_nxt  = una_sum[CB] ? '1 : una_sum[CB-1:0];
      all_nxt  = (|all_sum[65:64]) ? '1 : all_sum[63:0];
      err_nxt  = err_nxt | una_sum[CB] | (|all_sum[65:64]);
      gap_nxt  = '0;
      base_nxt = '0;
      pbv_nxt  = 1'b0;
      if (fin_restart) begin
        gap_nxt   = CB'(1);
        first_nxt = 1'b0;
      end
      res_push = (fin_g != '0) || (fin_b != '0) || fin_f;
    end

    g64   = 64'(fin_g);
    b64   = 64'(fin_b);
    seq64 = 64'(seq_nxt);
    una64 = 64'(una_nxt);

    res.kind              = fin ? fsp_pkg::KIND_RECORD : fsp_pkg::KIND_SYMBOL;
    res.symbol            = fin ? 2'd0 : sym;
    res.gap_count         = fin ? g64[31:0] : 32'd0;
    res.base_count        = fin ? b64[31:0] : 32'd0;
    res.first_of_sequence = fin ? fin_f : 1'b0;
    res.sequence_count    = seq64[31:0];
    res.unambiguous_total = una64[31:0];
    res.all_total         = all_nxt;
    res.overflow_error    = err_nxt;
  end

  assign stat.error    = err_r;
  assign stat.res_push = res_push;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= fsp_pkg::PH_START;
      gap_r   <= '0;
      base_r  <= '0;
      first_r <= 1'b1;
      pb_r    <= '0;
      pbv_r   <= 1'b0;
      seq_r   <= '0;
      una_r   <= '0;
      all_r   <= '0;
      err_r   <= 1'b0;
    end else begin
      phase_r <= phase_nxt;
      gap_r   <= gap_nxt;
      base_r  <= base_nxt;
      first_r <= first_nxt;
      pb_r    <= pb_nxt;
      pbv_r   <= pbv_nxt;
      seq_r   <= seq_nxt;
      una_r   <= una_nxt;
      all_r   <= all_nxt;
      err_r   <= err_nxt;
    end
  end

endmodule : fsp_back
`default_nettype wire

/* sv/fasta_stretch_parser.sv */
// FASTA stretch parser: takes one byte of FASTA text per cycle, unless in_full
// is high, through a push/full port and returns 2-bit base or color symbols
// and per-stretch records (gap count, base count, first-of-sequence, running
// totals) through an empty/pop port. A byte is taken every cycle while the
// consumer keeps popping; the parser updates all of its counters for a byte
// combinationally, so the sustained rate is one byte per clock. A byte is
// first registered in the front queue, the parser works on it and the result
// queue registers the result, which then shows at the output ports. The
// parser holds a byte only while the result queue is full. The four one-bit
// mode registers are written through cfg_we; the user must write them only
// while the block is idle, which the block itself does not enforce.
`default_nettype none
// ----------------------------------------------------------------------------
// fasta_stretch_parser: top level
// Configuration registers, classifier front end, parser back end and the
// result queue.
// ----------------------------------------------------------------------------
module fasta_stretch_parser #(
  parameter int unsigned COUNT_BITS  = fsp_pkg::COUNT_BITS_DEF,
  parameter int unsigned QUEUE_DEPTH = fsp_pkg::QUEUE_DEPTH_DEF
) (
  input  wire  logic                             clk,
  input  wire  logic                             rst_n,
  input  wire  logic                             cfg_we,
  input  wire  logic [fsp_pkg::CFG_IDX_BITS-1:0] cfg_index,
  input  wire  logic                             cfg_wdata,
  input  wire  logic                             in_push,
  output logic                                   in_full,
  input  wire  logic [7:0]                       in_char_byte,
  input  wire  logic                             in_file_start,
  input  wire  logic                             in_end_of_file,
  output logic                                   out_empty,
  input  wire  logic                             out_pop,
  output logic                                   out_kind,
  output logic [1:0]                             out_symbol,
  output logic [31:0]                            out_gap_count,
  output logic [31:0]                            out_base_count,
  output logic                                   out_first_of_sequence,
  output logic [31:0]                            out_sequence_count,
  output logic [31:0]                            out_unambiguous_total,
  output logic [63:0]                            out_all_total,
  output logic                                   out_overflow_error
);

  fsp_pkg::cfg_t       cfg_r, cfg_nxt;
  fsp_pkg::item_t      item;
  logic                item_valid;
  logic                item_pop;
  logic                res_full;
  logic                res_push;
  fsp_pkg::result_t    res_in;
  fsp_pkg::result_t    res_out;
  fsp_pkg::back_stat_t stat;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (cfg_index)
        fsp_pkg::CFG_AMBIGUOUS_TO_A: cfg_nxt.ambiguous_to_a = cfg_wdata;
        fsp_pkg::CFG_COLOR_SPACE:    cfg_nxt.color_space    = cfg_wdata;
        fsp_pkg::CFG_BISULFITE_MODE: cfg_nxt.bisulfite_mode = cfg_wdata;
        fsp_pkg::CFG_EMIT_SYMBOLS:   cfg_nxt.emit_symbols   = cfg_wdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '{ambiguous_to_a: 1'b0, color_space: 1'b0,
                 bisulfite_mode: 1'b0, emit_symbols: 1'b1};
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  fsp_front #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg            (cfg_r),
    .in_push        (in_push),
    .in_full        (in_full),
    .in_char_byte   (in_char_byte),
    .in_file_start  (in_file_start),
    .in_end_of_file (in_end_of_file),
    .item           (item),
    .item_valid     (item_valid),
    .item_pop       (item_pop)
  );

  fsp_back #(
    .COUNT_BITS (COUNT_BITS)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg_r),
    .item       (item),
    .item_valid (item_valid),
    .item_pop   (item_pop),
    .res_full   (res_full),
    .res_push   (res_push),
    .res        (res_in),
    .stat       (stat)
  );

  fsp_fifo #(
    .T     (fsp_pkg::result_t),
    .DEPTH (QUEUE_DEPTH)
  ) u_res_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (res_push),
    .wdata (res_in),
    .full  (res_full),
    .pop   (out_pop),
    .rdata (res_out),
    .empty (out_empty)
  );

  assign out_kind              = res_out.kind;
  assign out_symbol            = res_out.symbol;
  assign out_gap_count         = res_out.gap_count;
  assign out_base_count        = res_out.base_count;
  assign out_first_of_sequence = res_out.first_of_sequence;
  assign out_sequence_count    = res_out.sequence_count;
  assign out_unambiguous_total = res_out.unambiguous_total;
  assign out_all_total         = res_out.all_total;
  assign out_overflow_error    = res_out.overflow_error;

`ifndef SYNTHESIS
  a_error_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    stat.error |=> stat.error)
    else $error("overflow flag cleared without reset");

  a_no_push_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    stat.res_push |-> !res_full)
    else $error("result pushed into a full queue");

  a_result_only_from_item: assert property (@(posedge clk) disable iff (!rst_n)
    stat.res_push |-> item_pop)
    else $error("result produced without a parsed byte");

  a_record_clean_symbol: assert property (@(posedge clk) disable iff (!rst_n)
    (stat.res_push && res_in.kind == fsp_pkg::KIND_RECORD) |-> res_in.symbol == 2'd0)
    else $error("record carries a symbol");
`endif

endmodule : fasta_stretch_parser
`default_nettype wire
